// ===== rtl/srrw_pkg.sv =====
`default_nettype none

package srrw_pkg;

  // Default sizing of the receive window
  localparam int SEQ_SPACE_DEF    = 256;
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths of the frame, result and configuration channels
  localparam int SEQ_W  = 8;
  localparam int XOR_W  = 8;
  localparam int CHK_W  = 8;
  localparam int PAY_W  = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd10;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/srrw_ifs.sv =====
`default_nettype none

interface srrw_cfg_if import srrw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] win_width;

  modport source (output valid, output win_width, input ready);
  modport sink   (input valid, input win_width, output ready);
endinterface

interface srrw_frame_if import srrw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;
  logic [XOR_W-1:0] payload_xor;
  logic [CHK_W-1:0] frame_checksum;
  logic [PAY_W-1:0] payload;
  logic             force_corrupt;

  modport source (output valid, output seq_number, output payload_xor,
                  output frame_checksum, output payload, output force_corrupt,
                  input ready);
  modport sink   (input valid, input seq_number, input payload_xor,
                  input frame_checksum, input payload, input force_corrupt,
                  output ready);
endinterface

interface srrw_result_if import srrw_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [SEQ_W-1:0] seq_out;
  logic [PAY_W-1:0] payload_out;
  logic             last;

  modport source (output valid, output kind, output seq_out, output payload_out,
                  output last, input ready);
  modport sink   (input valid, input kind, input seq_out, input payload_out,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/selective_repeat_receiver_window.sv =====
`default_nettype none

// Selective-repeat ARQ receiver window. Each request on the frame channel is one
// frame header; the block answers with zero or more results on the result
// channel, the final one marked by last. A good frame inside the window is held
// in the payload RAM, every frame then in order at the window base is delivered
// upward (kind DELIVER) and an ACK follows; a bad frame inside the window gets a
// NACK, a frame up to one window below the base gets its ACK again, and any
// other frame is dropped without a result; a duplicate of a held frame gets
// only an ACK. Frames are handled one at a time: the next frame is taken
// only after every result of the last one has been taken. For each
// delivery the walk checks that the base slot is held (S_WALK), then
// reads that slot's payload from the payload RAM (S_READ)
// and then presents the word from the output register. The window width
// register may be written at any time the block holds no frame; 0 acts as 1
// and values above the ring depth or half the sequence space are capped.
module selective_repeat_receiver_window import srrw_pkg::*; #(
  parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  srrw_cfg_if.sink       cfg,
  srrw_frame_if.sink     frame,
  srrw_result_if.source  result
);

  localparam int SeqW   = $clog2(SEQ_SPACE);
  localparam int IdxW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int StoreW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int WinCap = (WINDOW_DEPTH < SEQ_SPACE / 2) ? WINDOW_DEPTH : SEQ_SPACE / 2;
  localparam int CmpW   = SeqW + 6;
  localparam int SeqTblN = 1 << SEQ_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_WALK,
    S_READ,
    S_OUT
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    win_cfg;
  logic [SeqW-1:0]     base;
  logic [IdxW-1:0]     head;
  logic [WINDOW_DEPTH-1:0] flags;

  // Latched frame
  logic [SeqW-1:0]     seq_m;
  logic                chk_ok;
  logic [StoreW-1:0]   pay_in;

  // Result register and where to go once it is taken
  logic                to_walk;
  kind_t               out_kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [PAY_W-1:0]    out_pay;
  logic                out_last;

  // Sequence number reduced modulo the sequence space, as a constant table
  logic [SeqW-1:0]     seq_mod_tbl [SeqTblN];

  for (genvar g = 0; g < SeqTblN; g++) begin : g_seq_tbl
    assign seq_mod_tbl[g] = SeqW'(g % SEQ_SPACE);
  end

  // Classification of the latched frame
  logic [SeqW:0]       diff;
  logic [SeqW-1:0]     offset;
  logic [CFG_W-1:0]    win;
  logic                in_win;
  logic                below;
  logic [IdxW:0]       slot_sum;
  logic [IdxW-1:0]     slot;
  logic                store_new;
  logic [IdxW-1:0]     head_inc;
  logic [SeqW-1:0]     base_inc;
  logic [StoreW-1:0]   rd_data;
  logic                rd_en;

  always_comb begin
    diff = {1'b0, seq_m} - {1'b0, base};
    if (diff[SeqW]) begin
      offset = SeqW'(diff + (SeqW+1)'(SEQ_SPACE));
    end else begin
      offset = diff[SeqW-1:0];
    end

    if (win_cfg == '0) begin
      win = CFG_W'(1);
    end else if (int'(win_cfg) > WinCap) begin
      win = CFG_W'(WinCap);
    end else begin
      win = win_cfg;
    end

    in_win = CmpW'(offset) < CmpW'(win);
    below  = CmpW'(offset) >= (CmpW'(SEQ_SPACE) - CmpW'(win));

    // offset stays below the depth whenever the slot is used
    slot_sum = (IdxW+1)'(head) + (IdxW+1)'(offset);
    if (int'(slot_sum) >= WINDOW_DEPTH) begin
      slot = IdxW'(int'(slot_sum) - WINDOW_DEPTH);
    end else begin
      slot = slot_sum[IdxW-1:0];
    end

    store_new = (state == S_CLASS) && in_win && chk_ok && !flags[slot];

    head_inc = (int'(head) == WINDOW_DEPTH - 1) ? '0 : head + IdxW'(1);
    base_inc = (int'(base) == SEQ_SPACE - 1) ? '0 : base + SeqW'(1);

    rd_en = (state == S_WALK) && flags[head];
  end

  srrw_payload_ram #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (StoreW)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (store_new),
    .wr_addr (slot),
    .wr_data (pay_in),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign cfg.ready   = 1'b1;
  assign frame.ready = (state == S_IDLE);

  assign result.valid       = (state == S_OUT);
  assign result.kind        = out_kind;
  assign result.seq_out     = out_seq;
  assign result.payload_out = out_pay;
  assign result.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win_cfg     <= WINDOW_RESET;
      base        <= '0;
      head        <= '0;
      flags       <= '0;
      to_walk     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        win_cfg <= cfg.win_width;
      end

      case (state)
        S_IDLE: begin
          // Take the frame: reduce the sequence number, check the sum
          if (frame.valid) begin
            seq_m  <= seq_mod_tbl[frame.seq_number];
            chk_ok <= ({1'b0, frame.frame_checksum} + 9'(frame.force_corrupt))
                      == {1'b0, frame.payload_xor};
            pay_in <= frame.payload[StoreW-1:0];
            state  <= S_CLASS;
          end
        end

        S_CLASS: begin
          if (in_win) begin
            if (!chk_ok) begin
              out_kind <= KIND_NACK;
              out_seq  <= SEQ_W'(seq_m);
              out_pay  <= '0;
              out_last <= 1'b1;
              to_walk  <= 1'b0;
              state    <= S_OUT;
            end else if (flags[slot]) begin
              // Duplicate: already held, only acknowledge
              out_kind <= KIND_ACK;
              out_seq  <= SEQ_W'(seq_m);
              out_pay  <= '0;
              out_last <= 1'b1;
              to_walk  <= 1'b0;
              state    <= S_OUT;
            end else begin
              // Payload goes to the RAM this cycle; mark the slot held
              flags[slot] <= 1'b1;
              state       <= S_WALK;
            end
          end else if (below) begin
            out_kind <= KIND_ACK;
            out_seq  <= SEQ_W'(seq_m);
            out_pay  <= '0;
            out_last <= 1'b1;
            to_walk  <= 1'b0;
            state    <= S_OUT;
          end else begin
            // Beyond the window: drop silently
            state <= S_IDLE;
          end
        end

        S_WALK: begin
          // Base slot held: fetch its payload, else close with the ACK
          if (flags[head]) begin
            state <= S_READ;
          end else begin
            out_kind <= KIND_ACK;
            out_seq  <= SEQ_W'(seq_m);
            out_pay  <= '0;
            out_last <= 1'b1;
            to_walk  <= 1'b0;
            state    <= S_OUT;
          end
        end

        S_READ: begin
          // Deliver the base frame, free its slot and advance the window
          out_kind    <= KIND_DELIVER;
          out_seq     <= SEQ_W'(base);
          out_pay     <= PAY_W'(rd_data);
          out_last    <= 1'b0;
          flags[head] <= 1'b0;
          head        <= head_inc;
          base        <= base_inc;
          to_walk     <= 1'b1;
          state       <= S_OUT;
        end

        S_OUT: begin
          if (result.ready) begin
            state <= to_walk ? S_WALK : S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A frame is taken only when no earlier frame is in flight
  assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> !frame.ready)
    else $error("frame accepted while another frame is in progress");

  // A delivery is read only from a slot that holds a frame
  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> flags[head])
    else $error("delivery from an empty slot");

  // A newly stored frame leaves its slot marked held
  assert property (@(posedge clk) disable iff (rst)
    store_new |=> flags[$past(slot)])
    else $error("stored frame not marked held");

  // The last result of a frame never walks on, a delivery always does
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (out_last != to_walk))
    else $error("last flag and walk continuation disagree");

endmodule

`default_nettype wire

// ===== rtl/srrw_payload_ram.sv =====
`default_nettype none

module srrw_payload_ram import srrw_pkg::*; #(
  parameter int DEPTH = WINDOW_DEPTH_DEF,
  parameter int WIDTH = PAYLOAD_BITS_DEF,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: rd_data loads mem[rd_addr] only while rd_en is high
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_selective_repeat_receiver_window.sv =====
`default_nettype none

module tb_selective_repeat_receiver_window;
  import srrw_pkg::*;

  // Cycles to let pass after the last expected result before a register
  // write: a dropped frame owes no result but still keeps the block busy.
  localparam int SETTLE_CYCLES  = 8;
  // Longest frame: one that releases a full window of held frames.
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_FRAMES   = 13;
  localparam int SHUFFLE_BLOCKS = 3;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [XOR_W-1:0] pxor;
    logic [CHK_W-1:0] chk;
    logic [PAY_W-1:0] pay;
    logic             corrupt;
  } frame_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] pay;
    logic             last;
  } answer_t;

  logic clk;
  logic rst;

  srrw_cfg_if    cfg_ch ();
  srrw_frame_if  frame_ch ();
  srrw_result_if result_ch ();

  selective_repeat_receiver_window dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .frame  (frame_ch),
    .result (result_ch)
  );

  // Predicted state of the receive window.
  logic [CFG_W-1:0] exp_window_reg;
  logic [SEQ_W-1:0] exp_base;
  logic [3:0]       exp_head;
  logic             exp_held [16];
  logic [PAY_W-1:0] exp_store [16];

  // Answers still owed by the block, oldest first.
  answer_t pending_answers [$];
  int      mismatch_count;

  // Idle switches: when set, that side never waits.
  bit src_quiet;
  bit sink_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Window width in effect: 0 acts as 1, anything past the ring depth is capped.
  function automatic int window_width();
    if (exp_window_reg == '0) return 1;
    if (exp_window_reg > 5'd16) return 16;
    return int'(exp_window_reg);
  endfunction

  function automatic void clear_window_state();
    exp_window_reg = WINDOW_RESET;
    exp_base       = '0;
    exp_head       = '0;
    for (int i = 0; i < 16; i++) begin
      exp_held[i]  = 1'b0;
      exp_store[i] = '0;
    end
  endfunction

  function automatic void owe_answer(kind_t kind, logic [SEQ_W-1:0] seq,
                                     logic [PAY_W-1:0] pay, logic last);
    answer_t a;
    a.kind = kind;
    a.seq  = seq;
    a.pay  = pay;
    a.last = last;
    pending_answers.push_back(a);
  endfunction

  // Work out every answer one accepted frame causes and advance the window.
  function automatic void predict_frame_answers(frame_t f);
    logic [SEQ_W-1:0] off;
    logic [CHK_W:0]   rx_sum;
    logic [3:0]       slot;
    int               width;
    int               steps;
    width  = window_width();
    off    = f.seq - exp_base;
    // Keep the ninth bit: a checksum of 255 plus injection matches nothing.
    rx_sum = {1'b0, f.chk} + {{CHK_W{1'b0}}, f.corrupt};
    if (int'(off) < width) begin
      if (rx_sum != {1'b0, f.pxor}) begin
        owe_answer(KIND_NACK, f.seq, '0, 1'b1);
        return;
      end
      slot = exp_head + off[3:0];
      // Store only new frames; a duplicate just gets its ACK.
      if (!exp_held[slot]) begin
        exp_held[slot]  = 1'b1;
        exp_store[slot] = f.pay;
        steps = 0;
        // Release every frame now in order at the base, held ones beyond a
        // shrunk window included.
        while (steps < 16 && exp_held[exp_head]) begin
          owe_answer(KIND_DELIVER, exp_base, exp_store[exp_head], 1'b0);
          exp_held[exp_head] = 1'b0;
          exp_head = exp_head + 4'd1;
          exp_base = exp_base + 8'd1;
          steps++;
        end
      end
      owe_answer(KIND_ACK, f.seq, '0, 1'b1);
    end else if (int'(off) >= 256 - width) begin
      // Up to one window below the base: ACK again.
      owe_answer(KIND_ACK, f.seq, '0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: draw a stall before each request, check each accepted one
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int gap;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      // Hold ready until a request is taken.
      while (!result_ch.valid) @(posedge clk);
    end
  end

  function automatic void report_mismatch(string what, answer_t want, answer_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected kind %0d seq %0d payload %h last %b, %s",
               what, want.kind, want.seq, want.pay, want.last,
               $sformatf("got kind %0d seq %0d payload %h last %b",
                         got.kind, got.seq, got.pay, got.last));
  endfunction

  always @(posedge clk) begin : check_answers
    answer_t want;
    answer_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind = result_ch.kind;
      got.seq  = result_ch.seq_out;
      got.pay  = result_ch.payload_out;
      got.last = result_ch.last;
      if (pending_answers.size() == 0) begin
        want = '0;
        report_mismatch("result with nothing expected", want, got);
      end else begin
        want = pending_answers.pop_front();
        if (got.kind !== want.kind || got.seq !== want.seq ||
            got.pay !== want.pay || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame and register drivers
  // ---------------------------------------------------------------------------

  function automatic frame_t make_frame(logic [SEQ_W-1:0] seq, logic [XOR_W-1:0] pxor,
                                        logic [CHK_W-1:0] chk, logic [PAY_W-1:0] pay,
                                        logic corrupt);
    frame_t f;
    f.seq     = seq;
    f.pxor    = pxor;
    f.chk     = chk;
    f.pay     = pay;
    f.corrupt = corrupt;
    return f;
  endfunction

  // Present one frame request and predict its answers once it is taken.
  // Valid stays high on return so that a back-to-back frame never lowers and
  // raises it in one step; whoever waits next drops it.
  task automatic send_frame(frame_t f);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid          <= 1'b1;
    frame_ch.seq_number     <= f.seq;
    frame_ch.payload_xor    <= f.pxor;
    frame_ch.frame_checksum <= f.chk;
    frame_ch.payload        <= f.pay;
    frame_ch.force_corrupt  <= f.corrupt;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    predict_frame_answers(f);
  endtask

  // Drop valid, wait for every owed answer, then let the block go idle.
  task automatic wait_idle(int extra);
    frame_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] value);
    wait_idle(SETTLE_CYCLES);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.win_width <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid   <= 1'b0;
    exp_window_reg = value;
  endtask

  // Good frame at an offset from the current base; sometimes pass the check
  // through corruption injection instead of an exact match (a zero xor then fails).
  task automatic send_good_at(int offset);
    logic [XOR_W-1:0] pxor;
    logic [CHK_W-1:0] chk;
    logic             corrupt;
    pxor    = XOR_W'($urandom);
    chk     = pxor;
    corrupt = 1'b0;
    if ($urandom_range(0, 3) == 0) begin
      corrupt = 1'b1;
      chk     = pxor - 8'd1;
    end
    send_frame(make_frame(SEQ_W'(int'(exp_base) + offset), pxor, chk, $urandom,
                          corrupt));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset width of 10: ordering, duplicates, checksums, and both window edges.
  task automatic test_directed_window();
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    send_frame(make_frame(8'd0,   8'h00, 8'h00, 32'h0000_0000, 1'b0)); // in order
    send_frame(make_frame(8'd2,   8'hA5, 8'hA5, 32'hFFFF_FFFF, 1'b0)); // hold ahead
    send_frame(make_frame(8'd2,   8'hA5, 8'hA5, 32'h5555_5555, 1'b0)); // duplicate
    send_frame(make_frame(8'd1,   8'h5A, 8'h5A, 32'h1234_5678, 1'b0)); // release two
    send_frame(make_frame(8'd3,   8'h3C, 8'h3D, 32'hAAAA_AAAA, 1'b0)); // bad checksum
    send_frame(make_frame(8'd3,   8'h80, 8'h7F, 32'h8000_0001, 1'b1)); // fixed by inject
    send_frame(make_frame(8'd4,   8'h00, 8'hFF, 32'hDEAD_BEEF, 1'b1)); // sum overflows
    send_frame(make_frame(8'd4,   8'hFF, 8'hFF, 32'h7FFF_FFFE, 1'b0));
    send_frame(make_frame(8'd0,   8'h11, 8'h11, 32'h0F0F_0F0F, 1'b0)); // below: ACK again
    send_frame(make_frame(8'd255, 8'h22, 8'h21, 32'hF0F0_F0F0, 1'b1)); // below across wrap
    send_frame(make_frame(8'd14,  8'h01, 8'h01, 32'hCAFE_F00D, 1'b0)); // top of window
    send_frame(make_frame(8'd15,  8'h02, 8'h02, 32'h0000_0001, 1'b1)); // one past: drop
    send_frame(make_frame(8'd133, 8'hFE, 8'hFE, 32'h8000_0000, 1'b0)); // far off: drop
    send_frame(make_frame(8'd250, 8'h77, 8'h77, 32'h0000_FFFF, 1'b0)); // just past below
    // Fill the window backward so the base frame releases ten at once.
    for (int s = 13; s >= 6; s--)
      send_frame(make_frame(8'(s), 8'(s * 7), 8'(s * 7), $urandom, 1'b0));
    send_frame(make_frame(8'd5, 8'hC3, 8'hC3, 32'hFFFF_0000, 1'b0));
  endtask

  // Width register at 0 (acts as 1) and at 31 (capped at the ring depth),
  // the latter with a full window released by one frame.
  task automatic test_window_limits();
    int order [16];
    int pick;
    int tmp;
    write_window(5'd0);
    send_good_at(1);      // outside a one-frame window
    send_good_at(0);
    send_good_at(-1);     // the one frame below
    send_good_at(-2);     // dropped
    write_window(5'd31);
    for (int i = 0; i < 15; i++) order[i] = i + 1;
    for (int i = 14; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[pick]; order[pick] = tmp;
    end
    for (int i = 0; i < 15; i++) send_good_at(order[i]);
    send_good_at(0);      // sixteen deliveries and an ACK
    send_good_at(16);     // just past the capped window
    send_good_at(-16);    // deepest below
  endtask

  // Shrink the window while frames are held; they stay and are released later.
  task automatic test_shrink_with_held();
    write_window(5'd16);
    for (int off = 3; off <= 12; off++) send_good_at(off);
    write_window(5'd3);
    send_good_at(2);
    send_good_at(1);
    send_good_at(12);     // held, but now outside: dropped
    send_good_at(0);
  endtask

  // Fill full windows in shuffled order and release each block in order.
  task automatic test_shuffled_blocks();
    int               order [16];
    int               pick;
    int               tmp;
    logic [SEQ_W-1:0] prev_base;
    write_window(5'd16);
    for (int blk = 0; blk < SHUFFLE_BLOCKS; blk++) begin
      src_quiet  = blk[0];
      sink_quiet = blk[0];
      prev_base  = exp_base;
      for (int i = 0; i < 16; i++) order[i] = i;
      for (int i = 15; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = order[i]; order[i] = order[pick]; order[pick] = tmp;
      end
      for (int i = 0; i < 16; i++)
        send_frame(make_frame(SEQ_W'(int'(prev_base) + order[i]), 8'(order[i]),
                              8'(order[i]), $urandom, 1'b0));
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // Mostly good frames scattered over the window, plus bad checksums, frames
  // below and beyond, and a few fully random headers.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] widths [RANDOM_PHASES];
    logic [SEQ_W-1:0] seq;
    logic [XOR_W-1:0] pxor;
    logic [CHK_W-1:0] chk;
    logic             corrupt;
    int               w;
    int               pick;
    widths[0] = 5'd1;
    widths[1] = 5'd16;
    widths[2] = 5'($urandom_range(2, 15));
    widths[3] = 5'($urandom_range(17, 31));
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_window(widths[ph]);
      src_quiet  = (ph == 0);
      sink_quiet = (ph == 0);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        w    = window_width();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_good_at($urandom_range(0, w - 1));
        end else begin
          pxor    = XOR_W'($urandom);
          chk     = CHK_W'($urandom);
          corrupt = 1'($urandom);
          if (pick < 72)
            seq = SEQ_W'(int'(exp_base) + int'($urandom_range(0, w - 1)));
          else if (pick < 85)
            seq = SEQ_W'(int'(exp_base) - int'($urandom_range(1, w)));
          else if (pick < 95)
            seq = SEQ_W'(int'(exp_base) + int'($urandom_range(w, 255 - w)));
          else
            seq = SEQ_W'($urandom);
          // Below-window frames are ACKed whatever their checksum.
          send_frame(make_frame(seq, pxor, chk, $urandom, corrupt));
        end
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    mismatch_count = 0;
    src_quiet      = 1'b0;
    sink_quiet     = 1'b0;
    clear_window_state();
    rst                     <= 1'b1;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.win_width        <= '0;
    frame_ch.valid          <= 1'b0;
    frame_ch.seq_number     <= '0;
    frame_ch.payload_xor    <= '0;
    frame_ch.frame_checksum <= '0;
    frame_ch.payload        <= '0;
    frame_ch.force_corrupt  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_window();
    test_window_limits();
    test_shrink_with_held();
    test_shuffled_blocks();
    test_random_traffic();

    wait_idle(DRAIN_CYCLES);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("tb_selective_repeat_receiver_window: PASS");
    end else begin
      $display("tb_selective_repeat_receiver_window: FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("tb_selective_repeat_receiver_window: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/srrw_pkg.sv
rtl/srrw_ifs.sv
rtl/srrw_payload_ram.sv
rtl/selective_repeat_receiver_window.sv
tb/tb_selective_repeat_receiver_window.sv
